// ===== sv/arc_pricing_price_out_engine_defines.svh =====
// Assertion macros for the arc pricing engine checker.
`ifndef ARC_PRICING_PRICE_OUT_ENGINE_DEFINES_SVH
`define ARC_PRICING_PRICE_OUT_ENGINE_DEFINES_SVH
// Implication that must hold at every clock edge outside reset.
`define APE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define APE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/ape_pkg.sv =====
// Shared types and constants for the arc pricing engine.
`timescale 1ns / 1ps
`default_nettype none
package ape_pkg;
  localparam int ARC_COUNT  = 4096;
  localparam int NODE_COUNT = 1024;
  localparam int ARC_AW     = $clog2(ARC_COUNT);
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] KIND_LOAD_ARC  = 3'd0;
  localparam logic [2:0] KIND_LOAD_NODE = 3'd1;
  localparam logic [2:0] KIND_PRICE     = 3'd2;
  localparam logic [2:0] KIND_CLOSE     = 3'd3;
  localparam logic [2:0] KIND_PRICE_OUT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARC, ST_TAIL, ST_HEAD, ST_APPLY, ST_OUT
  } state_t;

  // Sequencer controls for the datapath
  typedef struct packed {
    logic load_arc;
    logic load_node;
    logic cap_arc;
    logic cap_tail;
    logic cap_head;
    logic do_price;
    logic do_close;
    logic do_apply;
  } ctrl_t;
endpackage
`default_nettype wire

// ===== sv/arc_pricing_price_out_engine.sv =====
// Steps: loads and close act on acceptance; pricing item: arc, tail, head read;
// price-out: arc read, tail read, head read, write back, then result.
// Throughput: one item at a time, set by the single-port arc and node tables.
// Reset (rst, synchronous): search to largest value, objective zero, tables kept.
`timescale 1ns / 1ps
`default_nettype none
module arc_pricing_price_out_engine (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // kind[2:0]
  input  wire [2:0]    s_tuser,
  // arc_index[11:0] node_index[21:12] tail_node[31:22] head_node[41:32]
  // arc_cost_in[105:42] arc_flow_in[169:106] potential_in[233:170] pred_in[244:234]
  // depth_in[276:245] orient_in[278:277] tree_arc_in[291:279], zero pad to 296
  input  wire [295:0]  s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // result_kind
  output logic         m_tuser,
  // reduced_cost[63:0] arc_number[75:64] found[76] improved[77]
  // flow_out[141:78] objective_out[205:142], zero pad to 208
  output logic [207:0] m_tdata
);
  logic busy, in_fire, neg;
  ape_pkg::ctrl_t ctrl;
  logic [63:0] rc, fl, ob;
  logic [11:0] an;
  logic rk, fd, im;

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;

  ape_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .kind(s_tuser), .neg(neg),
    .out_taken(m_tready), .busy(busy), .out_valid(m_tvalid), .ctrl(ctrl)
  );

  ape_datapath u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire), .ctrl(ctrl),
    .arc_index(s_tdata[11:0]), .node_index(s_tdata[21:12]),
    .tail_node(s_tdata[31:22]), .head_node(s_tdata[41:32]),
    .arc_cost_in(s_tdata[105:42]), .arc_flow_in(s_tdata[169:106]),
    .potential_in(s_tdata[233:170]), .pred_in(s_tdata[244:234]),
    .depth_in(s_tdata[276:245]), .orient_in(s_tdata[278:277]),
    .tree_arc_in(s_tdata[291:279]),
    .neg(neg), .res_cost(rc), .res_arc(an), .res_found(fd), .res_improved(im),
    .res_flow(fl), .res_obj(ob), .res_kind(rk)
  );

  assign m_tuser = rk;
  assign m_tdata = {2'b00, ob, fl, im, fd, an, rc};
endmodule
`default_nettype wire

// ===== sv/ape_ctrl.sv =====
// Sequencer for the arc pricing engine.
`timescale 1ns / 1ps
`default_nettype none
module ape_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_fire,
  input  wire [2:0]        kind,
  input  wire              neg,
  input  wire              out_taken,
  output logic             busy,
  output logic             out_valid,
  output ape_pkg::ctrl_t   ctrl
);
  ape_pkg::state_t state, state_next;
  logic [2:0] kind_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ape_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
  always_ff @(posedge clk) begin
    if (in_fire) kind_r <= kind;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ape_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (kind == ape_pkg::KIND_PRICE || kind == ape_pkg::KIND_PRICE_OUT)
            state_next = ape_pkg::ST_ARC;
          else if (kind == ape_pkg::KIND_CLOSE) state_next = ape_pkg::ST_OUT;
        end
      end
      ape_pkg::ST_ARC:  state_next = ape_pkg::ST_TAIL;
      ape_pkg::ST_TAIL: state_next = ape_pkg::ST_HEAD;
      ape_pkg::ST_HEAD: state_next = (kind_r == ape_pkg::KIND_PRICE) ?
                                     ape_pkg::ST_IDLE : ape_pkg::ST_APPLY;
      ape_pkg::ST_APPLY: state_next = ape_pkg::ST_OUT;
      ape_pkg::ST_OUT:  if (out_taken) state_next = ape_pkg::ST_IDLE;
      default: state_next = ape_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    busy = (state != ape_pkg::ST_IDLE);
    out_valid = (state == ape_pkg::ST_OUT);
    unique case (state)
      ape_pkg::ST_IDLE: begin
        ctrl.load_arc  = in_fire && kind == ape_pkg::KIND_LOAD_ARC;
        ctrl.load_node = in_fire && kind == ape_pkg::KIND_LOAD_NODE;
        ctrl.do_close  = in_fire && kind == ape_pkg::KIND_CLOSE;
      end
      ape_pkg::ST_ARC:  ctrl.cap_arc = 1'b1;
      ape_pkg::ST_TAIL: ctrl.cap_tail = 1'b1;
      ape_pkg::ST_HEAD: begin
        ctrl.cap_head = 1'b1;
        ctrl.do_price = (kind_r == ape_pkg::KIND_PRICE);
      end
      ape_pkg::ST_APPLY: ctrl.do_apply = neg;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/ape_datapath.sv =====
// Tables and shared adder of the arc pricing engine.
`timescale 1ns / 1ps
`default_nettype none
module ape_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_fire,
  input  ape_pkg::ctrl_t       ctrl,
  input  wire [11:0]           arc_index,
  input  wire [9:0]            node_index,
  input  wire [9:0]            tail_node,
  input  wire [9:0]            head_node,
  input  wire [63:0]           arc_cost_in,
  input  wire [63:0]           arc_flow_in,
  input  wire [63:0]           potential_in,
  input  wire [10:0]           pred_in,
  input  wire [31:0]           depth_in,
  input  wire [1:0]            orient_in,
  input  wire [12:0]           tree_arc_in,
  output logic                 neg,
  output logic [63:0]          res_cost,
  output logic [11:0]          res_arc,
  output logic                 res_found,
  output logic                 res_improved,
  output logic [63:0]          res_flow,
  output logic [63:0]          res_obj,
  output logic                 res_kind
);
  localparam int AW = ape_pkg::ARC_AW;
  localparam int NW = ape_pkg::NODE_AW;

  logic [9:0]  a_tail [ape_pkg::ARC_COUNT];
  logic [9:0]  a_head [ape_pkg::ARC_COUNT];
  logic [63:0] a_cost [ape_pkg::ARC_COUNT];
  logic [63:0] a_flow [ape_pkg::ARC_COUNT];
  logic [63:0] n_pot   [ape_pkg::NODE_COUNT];
  logic [10:0] n_pred  [ape_pkg::NODE_COUNT];
  logic [31:0] n_depth [ape_pkg::NODE_COUNT];
  logic [1:0]  n_orient[ape_pkg::NODE_COUNT];
  logic [12:0] n_tree  [ape_pkg::NODE_COUNT];

  logic [AW-1:0] arc_r;
  logic [AW-1:0] arc_rd_addr;
  logic [9:0]  tail_r, head_r;
  logic [63:0] cost_r, flow_r, pot_rd, acc;
  logic [31:0] depth_rd;
  logic [NW-1:0] node_addr;
  logic [63:0] objective, best;
  logic [11:0] best_arc;
  logic        found;
  logic [63:0] sum;

  always_ff @(posedge clk) begin
    if (in_fire) arc_r <= arc_index[AW-1:0];
  end

  // Arc read starts on the accepting edge so the tail is ready in the next cycle
  assign arc_rd_addr = in_fire ? arc_index[AW-1:0] : arc_r;

  // Arc table: one port
  always_ff @(posedge clk) begin
    if (ctrl.load_arc) begin
      a_tail[arc_index[AW-1:0]] <= tail_node;
      a_head[arc_index[AW-1:0]] <= head_node;
      a_cost[arc_index[AW-1:0]] <= arc_cost_in;
      a_flow[arc_index[AW-1:0]] <= arc_flow_in;
    end else if (ctrl.do_apply) begin
      a_cost[arc_r] <= acc;
      a_flow[arc_r] <= flow_r + 64'd1;
    end
    tail_r <= a_tail[arc_rd_addr];
    head_r <= a_head[arc_rd_addr];
    cost_r <= a_cost[arc_rd_addr];
    flow_r <= a_flow[arc_rd_addr];
  end

  // Node table: load writes, or read tail, then head, then write head
  always_comb begin
    priority case (1'b1)
      ctrl.load_node: node_addr = node_index[NW-1:0];
      ctrl.cap_arc:   node_addr = tail_r[NW-1:0];
      default:        node_addr = head_r[NW-1:0];
    endcase
  end
  always_ff @(posedge clk) begin
    if (ctrl.load_node) begin
      n_pot[node_addr]    <= potential_in;
      n_pred[node_addr]   <= pred_in;
      n_depth[node_addr]  <= depth_in;
      n_orient[node_addr] <= orient_in;
      n_tree[node_addr]   <= tree_arc_in;
    end else if (ctrl.do_apply) begin
      n_pot[node_addr]    <= pot_rd + acc;
      n_pred[node_addr]   <= {1'b0, tail_r};
      n_depth[node_addr]  <= depth_rd + 32'd1;
      n_orient[node_addr] <= 2'd1;
      n_tree[node_addr]   <= {1'b0, arc_r};
    end
    pot_rd <= n_pot[node_addr];
    if (ctrl.cap_arc) depth_rd <= n_depth[node_addr];
  end

  // Shared adder: cost + pot[tail], then minus pot[head]
  assign sum = ctrl.cap_tail ? (cost_r + pot_rd) : (acc - pot_rd);
  always_ff @(posedge clk) begin
    if (ctrl.cap_tail || ctrl.cap_head) acc <= sum;
  end
  assign neg = acc[63];

  // Search and objective registers
  always_ff @(posedge clk) begin
    if (rst) begin
      objective <= '0;
      best      <= ape_pkg::MAX_S64;
      best_arc  <= '0;
      found     <= 1'b0;
    end else begin
      if (ctrl.do_price && (!found || $signed(sum) < $signed(best))) begin
        best     <= sum;
        best_arc <= {{(12-AW){1'b0}}, arc_r};
      end
      if (ctrl.do_price) found <= 1'b1;
      if (ctrl.do_apply) objective <= objective + acc;
      if (ctrl.do_close) begin
        best     <= ape_pkg::MAX_S64;
        best_arc <= '0;
        found    <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.do_close) begin
      res_kind <= 1'b0; res_cost <= best; res_arc <= best_arc;
      res_found <= found; res_improved <= 1'b0;
      res_flow <= '0; res_obj <= '0;
    end else if (ctrl.cap_head) begin
      res_kind <= 1'b1; res_cost <= sum; res_arc <= {{(12-AW){1'b0}}, arc_r};
      res_found <= 1'b0; res_improved <= sum[63];
      res_flow <= flow_r + {63'd0, sum[63]};
      res_obj <= objective + (sum[63] ? sum : 64'd0);
    end
  end
endmodule
`default_nettype wire

// ===== sv/ape_checker.sv =====
// Port-level checker for the arc pricing engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "arc_pricing_price_out_engine_defines.svh"
module ape_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_tready,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire         m_tuser,
  input wire [207:0] m_tdata
);
  `APE_ASSERT_IMPL(a_busy_out, clk, rst, m_tvalid, !s_tready, "input taken while result pending")
  `APE_ASSERT_NEXT(a_keep, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `APE_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "data held")
  `APE_ASSERT_NEXT(a_hold_user, clk, rst, m_tvalid && !m_tready, $stable(m_tuser), "kind held")
  `APE_ASSERT_IMPL(a_excl, clk, rst, m_tvalid, !(m_tdata[76] && m_tdata[77]), "found and improved")
endmodule
bind arc_pricing_price_out_engine ape_checker u_ape_checker (.*);
`default_nettype wire

// ===== verif/arc_pricing_price_out_engine_checker.sv =====
// Stream monitor, pricing and price-out predictor and result scoreboard for the arc pricing engine.
`timescale 1ns / 1ps
module arc_pricing_price_out_engine_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire [2:0]   s_tuser,
  input  wire [295:0] s_tdata,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire         m_tuser,
  input  wire [207:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [63:0] objective;
    logic [63:0] flow;
    logic        improved;
    logic        found;
    logic [11:0] arc;
    logic [63:0] reduced;
    logic        kind;
  } result_t;

  // Local copy of the engine tables
  logic [9:0]  tail_tab [ape_pkg::ARC_COUNT];
  logic [9:0]  head_tab [ape_pkg::ARC_COUNT];
  logic [63:0] cost_tab [ape_pkg::ARC_COUNT];
  logic [63:0] flow_tab [ape_pkg::ARC_COUNT];
  logic [63:0] pot_tab  [ape_pkg::NODE_COUNT];
  logic [10:0] pred_tab [ape_pkg::NODE_COUNT];
  logic [31:0] depth_tab[ape_pkg::NODE_COUNT];
  logic [1:0]  orient_tab[ape_pkg::NODE_COUNT];
  logic [12:0] tree_tab [ape_pkg::NODE_COUNT];
  logic [63:0] objective;
  logic [63:0] best;
  logic [11:0] best_arc;
  logic        search_hit;
  result_t     expected_q[$];

  function automatic logic [63:0] arc_reduced(logic [11:0] a);
    return cost_tab[a] + pot_tab[tail_tab[a]] - pot_tab[head_tab[a]];
  endfunction

  // Advance the predicted state by one accepted transfer
  task automatic predict_item(logic [2:0] kind, logic [295:0] d);
    logic [11:0] a;
    logic [9:0]  n;
    logic [63:0] r;
    result_t     res;
    a = d[11:0];
    n = d[21:12];
    res = '0;
    case (kind)
      ape_pkg::KIND_LOAD_ARC: begin
        tail_tab[a] = d[31:22];
        head_tab[a] = d[41:32];
        cost_tab[a] = d[105:42];
        flow_tab[a] = d[169:106];
      end
      ape_pkg::KIND_LOAD_NODE: begin
        pot_tab[n] = d[233:170];
        pred_tab[n] = d[244:234];
        depth_tab[n] = d[276:245];
        orient_tab[n] = d[278:277];
        tree_tab[n] = d[291:279];
      end
      ape_pkg::KIND_PRICE: begin
        r = arc_reduced(a);
        if (!search_hit || $signed(r) < $signed(best)) begin
          best = r;
          best_arc = a;
        end
        search_hit = 1'b1;
      end
      ape_pkg::KIND_CLOSE: begin
        res.kind = 1'b0;
        res.reduced = best;
        res.arc = best_arc;
        res.found = search_hit;
        expected_q = {expected_q, res};
        best = ape_pkg::MAX_S64;
        best_arc = '0;
        search_hit = 1'b0;
      end
      ape_pkg::KIND_PRICE_OUT: begin
        r = arc_reduced(a);
        if (r[63]) begin
          flow_tab[a] = flow_tab[a] + 64'd1;
          cost_tab[a] = r;
          pot_tab[head_tab[a]] = pot_tab[head_tab[a]] + r;
          pred_tab[head_tab[a]] = {1'b0, tail_tab[a]};
          depth_tab[head_tab[a]] = depth_tab[tail_tab[a]] + 32'd1;
          orient_tab[head_tab[a]] = 2'd1;
          tree_tab[head_tab[a]] = {1'b0, a};
          objective = objective + r;
        end
        res.kind = 1'b1;
        res.reduced = r;
        res.arc = a;
        res.improved = r[63];
        res.flow = flow_tab[a];
        res.objective = objective;
        expected_q = {expected_q, res};
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h actual %h", field, exp_v, act_v);
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      objective = '0;
      best = ape_pkg::MAX_S64;
      best_arc = '0;
      search_hit = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[205:0], m_tuser};
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'd0, m_tdata[63:0]);
        end else begin
          want = expected_q.pop_front();
          if (got.kind != want.kind)
            report("result_kind", 64'(want.kind), 64'(got.kind));
          if (got.reduced != want.reduced) report("reduced_cost", want.reduced, got.reduced);
          if (got.arc != want.arc) report("arc_number", 64'(want.arc), 64'(got.arc));
          if (got.found != want.found) report("found", 64'(want.found), 64'(got.found));
          if (got.improved != want.improved)
            report("improved", 64'(want.improved), 64'(got.improved));
          if (got.flow != want.flow) report("flow_out", want.flow, got.flow);
          if (got.objective != want.objective)
            report("objective_out", want.objective, got.objective);
        end
      end
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
    end
    pending = expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// ===== verif/arc_pricing_price_out_engine_tb.sv =====
// Stimulus, clocking and verdict for the arc pricing engine regression.
`timescale 1ns / 1ps
module arc_pricing_price_out_engine_tb;
  localparam int ARCS_USED  = 24;
  localparam int NODES_USED = 12;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [2:0]   s_tuser = '0;
  logic [295:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         m_tuser;
  logic [207:0] m_tdata;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  int           burst_left = 0;
  int           n_items = 0;
  logic [11:0]  arc_pool[$];

  arc_pricing_price_out_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  arc_pricing_price_out_engine_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: long ready runs mixed with stall stretches
  always @(negedge clk) begin
    if (cycles % 512 < 128) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return {$urandom, $urandom};
      3: return 64'(signed'($urandom_range(0, 40)) - 20);
      default: return {{32{1'b0}}, $urandom} - 64'h8000_0000;
    endcase
  endfunction

  // One transfer, sender bursts with random gaps between them
  task automatic send(logic [2:0] k, logic [295:0] d);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    n_items++;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic load_arc(logic [11:0] a, logic [9:0] t, logic [9:0] h,
                          logic [63:0] c, logic [63:0] f);
    logic [295:0] d;
    d = 296'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom});
    d[295:292] = '0;
    d[11:0] = a; d[31:22] = t; d[41:32] = h; d[105:42] = c; d[169:106] = f;
    send(ape_pkg::KIND_LOAD_ARC, d);
  endtask

  task automatic load_node(logic [9:0] n, logic [63:0] p, logic [10:0] pr,
                           logic [31:0] dp, logic [1:0] o, logic [12:0] ta);
    logic [295:0] d;
    d = 296'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom});
    d[295:292] = '0;
    d[21:12] = n; d[233:170] = p; d[244:234] = pr; d[276:245] = dp;
    d[278:277] = o; d[291:279] = ta;
    send(ape_pkg::KIND_LOAD_NODE, d);
  endtask

  task automatic arc_op(logic [2:0] k, logic [11:0] a);
    logic [295:0] d;
    d = '0;
    d[11:0] = a;
    send(k, d);
  endtask

  // Nodes in use: six low indices and six high ones up to the top node
  function automatic logic [9:0] node_at(int i);
    return (i < NODES_USED / 2) ? 10'(i) : 10'(1023 - (i - NODES_USED / 2));
  endfunction

  function automatic logic [9:0] node_pick();
    return node_at($urandom_range(0, NODES_USED - 1));
  endfunction

  task automatic random_arc_load();
    logic [11:0] a;
    a = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
                             : arc_pool[$urandom_range(0, ARCS_USED - 1)];
    load_arc(a, node_pick(), node_pick(), rand64(), rand64());
    arc_pool[$urandom_range(0, ARCS_USED - 1)] = a;
  endtask

  task automatic random_node_load();
    logic [9:0] n;
    n = node_pick();
    load_node(n, rand64(), 11'($urandom_range(0, 1024)) - 11'd1, {$urandom},
              2'($urandom_range(0, 2)) - 2'd1, 13'($urandom_range(0, 4096)) - 13'd1);
  endtask

  function automatic logic [11:0] loaded_arc();
    return arc_pool[$urandom_range(0, ARCS_USED - 1)];
  endfunction

  initial begin
    logic [2:0] junk;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every node in use gets loaded, field extremes, all kinds
    for (int i = 0; i < NODES_USED; i++) begin
      load_node(node_at(i), (i == 0) ? 64'h7FFF_FFFF_FFFF_FFFF : rand64(),
                (i == 1) ? 11'h7FF : 11'h3FF, (i == 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                (i == 3) ? 2'b11 : 2'b01, (i == 4) ? 13'h1FFF : 13'h0FFF);
    end
    // close with no arcs priced
    arc_op(ape_pkg::KIND_CLOSE, 12'd0);
    load_arc(12'd0, 10'd0, 10'd1023, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    load_arc(12'd4095, 10'd1023, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    load_arc(12'd7, 10'd1, 10'd1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    load_arc(12'd8, 10'd1, 10'd1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd5);
    for (int i = 0; i < ARCS_USED; i++) arc_pool = {arc_pool, (i % 2) ? 12'd7 : 12'd0};
    arc_pool[1] = 12'd4095;
    arc_pool[2] = 12'd8;
    // first arc at the largest value is taken; tie keeps the first
    arc_op(ape_pkg::KIND_PRICE, 12'd7);
    arc_op(ape_pkg::KIND_PRICE, 12'd8);
    arc_op(ape_pkg::KIND_CLOSE, 12'd0);
    arc_op(ape_pkg::KIND_PRICE, 12'd4095);
    arc_op(ape_pkg::KIND_PRICE, 12'd0);
    arc_op(ape_pkg::KIND_CLOSE, 12'd0);
    arc_op(ape_pkg::KIND_PRICE_OUT, 12'd0);
    arc_op(ape_pkg::KIND_PRICE_OUT, 12'd0);
    arc_op(ape_pkg::KIND_PRICE_OUT, 12'd7);
    arc_op(3'd5, 12'd0);
    arc_op(3'd7, 12'd4095);

    // Random: pricing calls and price-outs on loaded arcs, reloads and unused kinds
    while (n_items < 1850) begin
      case ($urandom_range(0, 9))
        0: random_arc_load();
        1: random_node_load();
        2, 3, 4: begin
          repeat ($urandom_range(0, 6)) arc_op(ape_pkg::KIND_PRICE, loaded_arc());
          arc_op(ape_pkg::KIND_CLOSE, 12'($urandom));
        end
        5, 6, 7: arc_op(ape_pkg::KIND_PRICE_OUT, loaded_arc());
        8: arc_op(ape_pkg::KIND_PRICE, loaded_arc());
        default: begin
          junk = 3'($urandom_range(5, 7));
          arc_op(junk, 12'($urandom));
        end
      endcase
    end
    arc_op(ape_pkg::KIND_CLOSE, 12'd0);
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/ape_pkg.sv
sv/ape_ctrl.sv
sv/ape_datapath.sv
sv/arc_pricing_price_out_engine.sv
sv/ape_checker.sv
verif/arc_pricing_price_out_engine_checker.sv
verif/arc_pricing_price_out_engine_tb.sv
